// ===== rtl/core/rtpjb_pkg.sv =====
// Shared types, constants and helpers for the RTP jitter and reorder buffer.
// No dependencies; every other file of the block except rtpjb_ram imports this package.
`default_nettype none

package rtpjb_pkg;

	// Field widths of the transaction payloads.
	localparam int ACT_W    = 2;
	localparam int SEQ_W    = 16;
	localparam int TS_W     = 32;
	localparam int STAT_W   = 4;
	localparam int SLOT_O_W = 9;
	localparam int SFILL_W  = 10;

	// Reset value of the start fill register.
	localparam logic [SFILL_W-1:0] START_FILL_RESET = 10'd220;

	// Slot tags: a slot is ready when its tag equals the current epoch.
	// Tag zero never matches, so it marks an empty slot.
	localparam int                 EPOCH_W     = 4;
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 4'd0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 4'd15;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUT   = 2'd0,
		ACT_GET   = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_IN_ORDER  = 4'd0,
		ST_AFTER_GAP = 4'd1,
		ST_LATE_USED = 4'd2,
		ST_DUPLICATE = 4'd3,
		ST_TOO_LATE  = 4'd4,
		ST_FRAME     = 4'd5,
		ST_NO_DATA   = 4'd6,
		ST_MISSING   = 4'd7,
		ST_FLUSHED   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_PEND,
		S_IDLE,
		S_MUL,
		S_LOOK,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic mul;
		logic look;
		logic exec;
		logic sweep;
		logic pend;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_nop;
		logic out_busy;
		logic need_sweep;
		logic sweep_last;
	} sts_t;

	// One result transaction.
	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic                resend_req;
		logic [SEQ_W-1:0]    resend_first;
		logic [SEQ_W-1:0]    resend_last;
		logic [SLOT_O_W-1:0] frame_slot;
		logic [SEQ_W-1:0]    frame_seq;
		logic [TS_W-1:0]     frame_time;
		logic                resume_out;
		logic                pause_flag;
		logic signed [15:0]  fill_level;
	} result_t;

	// Signed wrapping distance from one sequence number to another.
	function automatic logic signed [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from_seq,
			input logic [SEQ_W-1:0] to_seq);
		return signed'(to_seq - from_seq);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtpjb_if.sv =====
// Channel interfaces of the jitter buffer: request, result and configuration.
// Depends on rtpjb_pkg for the field widths.
`default_nettype none

interface rtpjb_req_if;
	import rtpjb_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [SEQ_W-1:0]  seq_num;
	logic [TS_W-1:0]   time_stamp;
	modport source (output valid, action, seq_num, time_stamp, input ready);
	modport sink   (input valid, action, seq_num, time_stamp, output ready);
endinterface

interface rtpjb_rsp_if;
	import rtpjb_pkg::*;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic                resend_req;
	logic [SEQ_W-1:0]    resend_first;
	logic [SEQ_W-1:0]    resend_last;
	logic [SLOT_O_W-1:0] frame_slot;
	logic [SEQ_W-1:0]    frame_seq;
	logic [TS_W-1:0]     frame_time;
	logic                resume_out;
	logic                pause_flag;
	logic signed [15:0]  fill_level;
	modport source (output valid, status, resend_req, resend_first, resend_last, frame_slot,
		frame_seq, frame_time, resume_out, pause_flag, fill_level, input ready);
	modport sink   (input valid, status, resend_req, resend_first, resend_last, frame_slot,
		frame_seq, frame_time, resume_out, pause_flag, fill_level, output ready);
endinterface

interface rtpjb_cfg_if;
	import rtpjb_pkg::*;
	logic               valid;
	logic               ready;
	logic [SFILL_W-1:0] start_fill;
	modport source (output valid, start_fill, input ready);
	modport sink   (input valid, start_fill, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rtpjb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rtpjb_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 512,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; read data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/rtpjb_ctrl.sv =====
// Controller state machine of the jitter buffer: sequences accept, slot index,
// lookup, execute and tag sweeps. Depends on rtpjb_pkg.
`default_nettype none

module rtpjb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rtpjb_pkg::sts_t sts,
	output rtpjb_pkg::cmd_t cmd
);
	import rtpjb_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register; reset starts with a sweep of the tag memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_PEND;
				end
			end
			S_PEND: begin
				cmd.pend = 1'b1;
				state_d  = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					if (!sts.in_nop) begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				// Wait until the result register can take the new result.
				if (!sts.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = sts.need_sweep ? S_CLEAR : S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/rtpjb_dp.sv =====
// Datapath of the jitter buffer: pointers, flags, slot index unit, slot
// memories and result register. Depends on rtpjb_pkg, rtpjb_if, rtpjb_ram.
`default_nettype none

module rtpjb_dp #(
	parameter int  DEPTH = 512,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rtpjb_pkg::ACT_W-1:0]     in_action,
	input  logic [rtpjb_pkg::SEQ_W-1:0]     in_seq,
	input  logic [rtpjb_pkg::TS_W-1:0]      in_time,
	input  logic                            cfg_we,
	input  logic [rtpjb_pkg::SFILL_W-1:0]   cfg_start_fill,
	input  rtpjb_pkg::cmd_t                 cmd,
	output rtpjb_pkg::sts_t                 sts,
	rtpjb_rsp_if.source                     rsp
);
	import rtpjb_pkg::*;

	// Reciprocal for the slot index: floor(seq / DEPTH) is off by at most one.
	localparam logic [31:0]          RECIP     = 32'((64'd1 << 32) / DEPTH);
	localparam logic [SEQ_W-1:0]     DEPTH_U   = SEQ_W'(DEPTH);
	localparam logic signed [15:0]   DEPTH_S   = 16'(DEPTH);
	localparam logic [AW-1:0]        LAST_SLOT = AW'(DEPTH - 1);

	// Architectural state.
	logic [SEQ_W-1:0]   rp_q, wp_q;
	logic               synced_q, buffering_q, paused_q;
	logic [SFILL_W-1:0] start_fill_q;
	logic [EPOCH_W-1:0] epoch_q;

	// Per-transaction pipeline registers.
	action_t            act_s1;
	logic [SEQ_W-1:0]   seq_s1, key_s1;
	logic [TS_W-1:0]    ts_s1;
	logic [47:0]        prod_s2;
	logic [AW-1:0]      slot_s3;

	// Tag sweep and the put write deferred behind it.
	logic [AW-1:0]      clr_cnt_q;
	logic               pend_q;
	logic [AW-1:0]      pend_slot_q;

	// Result register.
	logic               out_valid_q;
	result_t            res_q;

	// Memory ports.
	logic [EPOCH_W-1:0] tag_rdata, tag_wdata;
	logic [AW-1:0]      tag_waddr;
	logic               tag_we;
	logic [TS_W-1:0]    time_rdata;
	logic [AW-1:0]      slot_look;

	// Execute-stage results.
	result_t            res;
	logic [SEQ_W-1:0]   rp_n, wp_n, rp_a, wp_a;
	logic               synced_n, buf_n, paused_n;
	logic [EPOCH_W-1:0] epoch_n;
	logic               resync, store, need_sweep, tag_hit, tag_we_x;
	logic [EPOCH_W-1:0] tag_wdata_x;
	logic signed [15:0] fill_now, ahead, dist_w, fill_put;
	logic               over_now;
	logic [SEQ_W-1:0]   get_key;

	// Fill level from the current pointers and the overrun-adjusted read pointer.
	assign fill_now = seq_dist(rp_q, wp_q);
	assign over_now = fill_now >= DEPTH_S;
	assign get_key  = over_now ? (wp_q - {6'd0, start_fill_q}) : rp_q;

	// Capture the request and the sequence number whose slot is needed.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_s1 <= action_t'(in_action);
			seq_s1 <= in_seq;
			ts_s1  <= in_time;
			key_s1 <= (in_action == ACT_GET) ? get_key : in_seq;
		end
	end

	// Slot index, first step: multiply by the reciprocal.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2 <= 48'(key_s1) * 48'(RECIP);
		end
	end

	// Slot index, second step: remainder with one correction, then memory read.
	logic [SEQ_W-1:0] quot, rem, rem_fix;
	always_comb begin
		quot      = prod_s2[47:32];
		rem       = key_s1 - SEQ_W'(quot * DEPTH_U);
		rem_fix   = (rem >= DEPTH_U) ? (rem - DEPTH_U) : rem;
		slot_look = rem_fix[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			slot_s3 <= slot_look;
		end
	end

	// Execute: classify the transaction and work out the next state.
	always_comb begin
		res         = '0;
		rp_n        = rp_q;
		wp_n        = wp_q;
		synced_n    = synced_q;
		buf_n       = buffering_q;
		paused_n    = paused_q;
		resync      = 1'b0;
		store       = 1'b0;
		tag_we_x    = 1'b0;
		tag_wdata_x = EPOCH_NONE;
		fill_put    = '0;
		tag_hit     = (tag_rdata == epoch_q);
		rp_a        = synced_q ? rp_q : seq_s1;
		wp_a        = synced_q ? wp_q : (seq_s1 - 16'd1);
		ahead       = seq_dist(rp_a, seq_s1);
		dist_w      = seq_dist(wp_a, seq_s1);
		unique case (act_s1)
			ACT_PUT: begin
				rp_n           = rp_a;
				wp_n           = wp_a;
				synced_n       = 1'b1;
				res.frame_slot = SLOT_O_W'(slot_s3);
				// A packet too far ahead of the read pointer forces a resync unless buffering.
				resync = !buffering_q && (ahead >= DEPTH_S);
				if (resync) begin
					synced_n = 1'b0;
					buf_n    = 1'b1;
					paused_n = 1'b1;
				end
				if (!resync && tag_hit) begin
					res.status = ST_DUPLICATE;
				end else begin
					store = 1'b1;
					if (dist_w == 16'sd1) begin
						wp_n       = seq_s1;
						res.status = ST_IN_ORDER;
					end else if (dist_w > 16'sd1) begin
						res.resend_req   = 1'b1;
						res.resend_first = wp_a + 16'd1;
						res.resend_last  = seq_s1 - 16'd1;
						wp_n             = seq_s1;
						res.status       = ST_AFTER_GAP;
					end else if (ahead > 16'sd0) begin
						res.status = ST_LATE_USED;
					end else begin
						res.status = ST_TOO_LATE;
						store      = 1'b0;
					end
					// Buffering ends once the fill reaches the start fill.
					fill_put = seq_dist(rp_a, wp_n);
					if (buf_n && (fill_put >= $signed({6'd0, start_fill_q}))) begin
						buf_n          = 1'b0;
						paused_n       = 1'b0;
						res.resume_out = 1'b1;
					end
				end
			end
			ACT_GET: begin
				if (buffering_q || (fill_now < 16'sd1)) begin
					res.status = ST_NO_DATA;
				end else begin
					rp_n           = key_s1 + 16'd1;
					res.frame_slot = SLOT_O_W'(slot_s3);
					res.frame_seq  = key_s1;
					if (tag_hit) begin
						res.status     = ST_FRAME;
						res.frame_time = time_rdata;
						tag_we_x       = 1'b1;
						tag_wdata_x    = EPOCH_NONE;
					end else begin
						res.status = ST_MISSING;
					end
				end
			end
			ACT_FLUSH: begin
				resync     = 1'b1;
				synced_n   = 1'b0;
				buf_n      = 1'b1;
				paused_n   = 1'b1;
				res.status = ST_FLUSHED;
			end
			default: begin
				res.status = ST_NO_DATA;
			end
		endcase

		// A resync moves to a new epoch; running out of epochs needs a sweep.
		need_sweep = resync && (epoch_q == EPOCH_MAX);
		if (!resync) begin
			epoch_n = epoch_q;
		end else if (need_sweep) begin
			epoch_n = EPOCH_FIRST;
		end else begin
			epoch_n = epoch_q + EPOCH_W'(1);
		end
		if (store) begin
			tag_we_x    = !need_sweep;
			tag_wdata_x = epoch_n;
		end

		res.pause_flag = paused_n;
		res.fill_level = signed'(wp_n - rp_n);
	end

	// Control state and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q         <= '0;
			wp_q         <= '0;
			synced_q     <= 1'b0;
			buffering_q  <= 1'b1;
			paused_q     <= 1'b0;
			epoch_q      <= EPOCH_FIRST;
			start_fill_q <= START_FILL_RESET;
			clr_cnt_q    <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_fill_q <= cfg_start_fill;
			end
			if (cmd.exec) begin
				rp_q        <= rp_n;
				wp_q        <= wp_n;
				synced_q    <= synced_n;
				buffering_q <= buf_n;
				paused_q    <= paused_n;
				epoch_q     <= epoch_n;
				pend_q      <= need_sweep && store;
			end else if (cmd.pend) begin
				pend_q <= 1'b0;
			end
			if (cmd.sweep) begin
				clr_cnt_q <= (clr_cnt_q == LAST_SLOT) ? '0 : (clr_cnt_q + AW'(1));
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q       <= res;
			pend_slot_q <= slot_s3;
		end
	end

	// Tag memory write port: sweep, deferred put, or execute.
	always_comb begin
		priority if (cmd.sweep) begin
			tag_we    = 1'b1;
			tag_waddr = clr_cnt_q;
			tag_wdata = EPOCH_NONE;
		end else if (cmd.pend) begin
			tag_we    = pend_q;
			tag_waddr = pend_slot_q;
			tag_wdata = EPOCH_FIRST;
		end else begin
			tag_we    = cmd.exec && tag_we_x;
			tag_waddr = slot_s3;
			tag_wdata = tag_wdata_x;
		end
	end

	rtpjb_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (cmd.look),
		.raddr (slot_look),
		.rdata (tag_rdata)
	);

	rtpjb_ram #(
		.WIDTH (TS_W),
		.DEPTH (DEPTH)
	) u_time_ram (
		.clk   (clk),
		.we    (cmd.exec && store),
		.waddr (slot_s3),
		.wdata (ts_s1),
		.re    (cmd.look),
		.raddr (slot_look),
		.rdata (time_rdata)
	);

	// Status to the controller.
	assign sts.in_nop     = (in_action == ACT_NOP);
	assign sts.out_busy   = out_valid_q && !rsp.ready;
	assign sts.need_sweep = need_sweep;
	assign sts.sweep_last = (clr_cnt_q == LAST_SLOT);

	// Result channel.
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = res_q.status;
	assign rsp.resend_req   = res_q.resend_req;
	assign rsp.resend_first = res_q.resend_first;
	assign rsp.resend_last  = res_q.resend_last;
	assign rsp.frame_slot   = res_q.frame_slot;
	assign rsp.frame_seq    = res_q.frame_seq;
	assign rsp.frame_time   = res_q.frame_time;
	assign rsp.resume_out   = res_q.resume_out;
	assign rsp.pause_flag   = res_q.pause_flag;
	assign rsp.fill_level   = res_q.fill_level;

endmodule

`default_nettype wire

// ===== rtl/core/rtp_jitter_reorder_buffer_unit.sv =====
// Top level of the RTP jitter and reorder buffer: controller plus datapath.
// Depends on rtpjb_pkg, rtpjb_if, rtpjb_ctrl, rtpjb_dp and rtpjb_ram.
//
//   Channel  Dir  Handshake     Payload
//   cfg      in   valid/ready   start_fill
//   req      in   valid/ready   action, seq_num, time_stamp
//   rsp      out  valid/ready   status, resend_*, frame_*, resume_out, pause_flag, fill_level
//
// A put, get or flush passes four states: accept, reciprocal multiply for the slot
// index, remainder and slot memory read, execute with the memory read-modify-write.
// The result is registered out of execute, and the next request is taken only after
// execute, so a new request is taken only once the last one has executed.
// Action 3 is taken without leaving idle and gives no result. Reset and every
// fifteenth resync sweep the slot tag memory and then write any deferred put, during
// which req is not ready. A stalled rsp holds its result; one new request is taken
// meanwhile and waits in execute. cfg is always ready.
`default_nettype none

module rtp_jitter_reorder_buffer_unit #(
	parameter int DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	rtpjb_cfg_if.sink   cfg,
	rtpjb_req_if.sink   req,
	rtpjb_rsp_if.source rsp
);
	import rtpjb_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// Configuration writes are taken in any cycle.
	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	rtpjb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtpjb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_action      (req.action),
		.in_seq         (req.seq_num),
		.in_time        (req.time_stamp),
		.cfg_we         (cfg.valid),
		.cfg_start_fill (cfg.start_fill),
		.cmd            (cmd),
		.sts            (sts),
		.rsp            (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/core/rtpjb_chk.sv =====
// Port-level checker for the jitter buffer and its bind to the top level.
// Depends on rtpjb_pkg and rtp_jitter_reorder_buffer_unit.
`default_nettype none

module rtpjb_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [rtpjb_pkg::STAT_W-1:0]   status,
	input logic                           resend_req,
	input logic                           resume_out,
	input logic                           pause_flag,
	input logic [rtpjb_pkg::TS_W-1:0]     frame_time
);
	import rtpjb_pkg::*;

	// A stalled result transaction stays and keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(frame_time))
		else $error("result changed while stalled");

	// A flush always leaves the output paused.
	a_flush_pause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FLUSHED) |-> pause_flag)
		else $error("flush without pause");

	// Resuming happens only on a stored or too-late put and clears the pause.
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && resume_out |-> !pause_flag &&
			((status == ST_IN_ORDER) || (status == ST_AFTER_GAP) ||
			 (status == ST_LATE_USED) || (status == ST_TOO_LATE)))
		else $error("resume on a wrong transaction");

	// A resend request comes only with a gap.
	a_resend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && resend_req |-> (status == ST_AFTER_GAP))
		else $error("resend request without a gap");

	// Only a delivered frame carries a timestamp.
	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_FRAME) |-> (frame_time == '0))
		else $error("timestamp on a result that is not a frame");

endmodule

bind rtp_jitter_reorder_buffer_unit rtpjb_chk u_rtpjb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.resend_req (rsp.resend_req),
	.resume_out (rsp.resume_out),
	.pause_flag (rsp.pause_flag),
	.frame_time (rsp.frame_time)
);

`default_nettype wire
